/* sv/i2cmb_pkg.sv */
// shared types and constants of the i2c master byte engine
`timescale 1ns / 1ps
`default_nettype none

package i2cmb_pkg;

    localparam int TIMER_WIDTH_DEFAULT   = 8;
    localparam int STRETCH_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT   = 2;
    localparam int CFG_ADDR_WIDTH        = 3;
    localparam int CFG_DATA_WIDTH        = 32;

    localparam logic [7:0]  HALF_PERIOD_RESET   = 8'd5;
    localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;
    localparam logic [7:0]  ZERO_HALF_TICKS     = 8'd5;
    localparam logic [3:0]  BITS_PER_BYTE       = 4'd8;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_WR_BYTE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    typedef enum logic {
        REG_HALF_PERIOD   = 1'b0,
        REG_STRETCH_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRW1,
        ST_SRW2,
        ST_SD1,
        ST_SD2,
        ST_PD0,
        ST_PRW1,
        ST_PRW2,
        ST_PD1,
        ST_WD0,
        ST_WRW1,
        ST_WRW2,
        ST_WD1,
        ST_RRW1,
        ST_RRW2,
        ST_RD1,
        ST_AD0,
        ST_ARW1,
        ST_ARW2,
        ST_AD1
    } step_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

`default_nettype wire

/* sv/i2cmb_if.sv */
// item channels of the i2c master byte engine
`timescale 1ns / 1ps
`default_nettype none

interface i2cmb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;

    modport source (output valid, operation, tx_byte, send_ack, scl_in, sda_in, input ready);
    modport sink   (input valid, operation, tx_byte, send_ack, scl_in, sda_in, output ready);
endinterface

interface i2cmb_res_if;
    logic       valid;
    logic       ready;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       stretch_timeout;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
                    ack_received, stretch_timeout, input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
                    ack_received, stretch_timeout, output ready);
endinterface

`default_nettype wire

/* sv/i2cmb_front.sv */
// front end: takes tick items and classifies the command field
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_front (
    i2cmb_cmd_if.sink          cmd_ch,
    input  i2cmb_pkg::q_status_t q_status,
    output logic               push,
    output i2cmb_pkg::item_t   item
);

    i2cmb_pkg::cmd_t cmd;

    always_comb
    begin
        case (cmd_ch.operation)
            i2cmb_pkg::OP_START:   cmd = i2cmb_pkg::CMD_START;
            i2cmb_pkg::OP_STOP:    cmd = i2cmb_pkg::CMD_STOP;
            i2cmb_pkg::OP_WR_BYTE: cmd = i2cmb_pkg::CMD_WRITE;
            i2cmb_pkg::OP_READ:    cmd = i2cmb_pkg::CMD_READ;
            default:               cmd = i2cmb_pkg::CMD_NONE;
        endcase
    end

    assign cmd_ch.ready  = !q_status.full;
    assign push          = cmd_ch.valid && !q_status.full;
    assign item.cmd      = cmd;
    assign item.tx_byte  = cmd_ch.tx_byte;
    assign item.send_ack = cmd_ch.send_ack;
    assign item.scl_in   = cmd_ch.scl_in;
    assign item.sda_in   = cmd_ch.sda_in;

endmodule

`default_nettype wire

/* sv/i2cmb_queue.sv */
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_queue #(
    parameter int DEPTH = i2cmb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  i2cmb_pkg::item_t       push_item,
    input  logic                   pop,
    output i2cmb_pkg::q_status_t   status,
    output i2cmb_pkg::item_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cmb_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.valid = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* sv/i2cmb_back.sv */
// back end: bit sequencer with stretch timeout and result register
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_back #(
    parameter int TIMER_WIDTH   = i2cmb_pkg::TIMER_WIDTH_DEFAULT,
    parameter int STRETCH_WIDTH = i2cmb_pkg::STRETCH_WIDTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  i2cmb_pkg::q_status_t      q_status,
    input  i2cmb_pkg::item_t          q_item,
    output logic                      q_pop,
    input  logic [TIMER_WIDTH-1:0]    half_ticks,
    input  logic [STRETCH_WIDTH-1:0]  stretch_lim,
    i2cmb_res_if.source               res_ch
);

    i2cmb_pkg::step_t step_reg, step_next;
    logic [3:0]               bit_reg, bit_next;
    logic [7:0]               shift_reg, shift_next;
    logic [TIMER_WIDTH-1:0]   timer_reg, timer_next;
    logic [STRETCH_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     scl_drive_reg, scl_drive_next;
    logic                     sda_drive_reg, sda_drive_next;
    logic                     ack_choice_reg, ack_choice_next;
    logic [7:0]               rx_hold_reg, rx_hold_next;
    logic                     ack_hold_reg, ack_hold_next;
    logic                     timeout_reg, timeout_next;
    logic                     done_reg, done_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     fire;

    assign fire  = q_status.valid && (!out_valid_reg || res_ch.ready);
    assign q_pop = fire;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // next state of the sequencer for the tick at the queue head
    always_comb
    begin : engine_next
        logic                     stretched;
        logic                     rw_fail;
        logic                     rw_wait;
        logic [STRETCH_WIDTH-1:0] rw_cnt;

        step_next       = step_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        timer_next      = timer_reg;
        cnt_next        = cnt_reg;
        scl_drive_next  = scl_drive_reg;
        sda_drive_next  = sda_drive_reg;
        ack_choice_next = ack_choice_reg;
        rx_hold_next    = rx_hold_reg;
        ack_hold_next   = ack_hold_reg;
        timeout_next    = timeout_reg;
        done_next       = 1'b0;

        stretched = (step_reg inside {i2cmb_pkg::ST_SRW2, i2cmb_pkg::ST_PRW2,
                                      i2cmb_pkg::ST_WRW2, i2cmb_pkg::ST_RRW2,
                                      i2cmb_pkg::ST_ARW2});
        rw_fail   = stretched && (cnt_reg >= stretch_lim);
        rw_wait   = !rw_fail && !q_item.scl_in;
        rw_cnt    = (stretched && !rw_fail) ? cnt_reg + STRETCH_WIDTH'(1) : cnt_reg;

        if (step_reg == i2cmb_pkg::ST_IDLE)
        begin
            if (q_item.cmd != i2cmb_pkg::CMD_NONE)
            begin
                timeout_next = 1'b0;
                bit_next     = '0;
                timer_next   = half_ticks;
            end
            case (q_item.cmd)
                i2cmb_pkg::CMD_START:
                begin
                    sda_drive_next = 1'b0;
                    scl_drive_next = 1'b0;
                    cnt_next       = '0;
                    step_next      = i2cmb_pkg::ST_SRW1;
                end
                i2cmb_pkg::CMD_STOP:
                begin
                    sda_drive_next = 1'b1;
                    step_next      = i2cmb_pkg::ST_PD0;
                end
                i2cmb_pkg::CMD_WRITE:
                begin
                    ack_hold_next  = 1'b0;
                    sda_drive_next = !q_item.tx_byte[7];
                    shift_next     = {q_item.tx_byte[6:0], 1'b0};
                    step_next      = i2cmb_pkg::ST_WD0;
                end
                i2cmb_pkg::CMD_READ:
                begin
                    ack_choice_next = q_item.send_ack;
                    shift_next      = '0;
                    sda_drive_next  = 1'b0;
                    scl_drive_next  = 1'b0;
                    cnt_next        = '0;
                    step_next       = i2cmb_pkg::ST_RRW1;
                end
                default:
                begin
                    step_next = i2cmb_pkg::ST_IDLE;
                end
            endcase
        end
        else if (timer_reg > TIMER_WIDTH'(1))
        begin
            timer_next = timer_reg - TIMER_WIDTH'(1);
        end
        else
        begin
            timer_next = half_ticks;
            case (step_reg)
                i2cmb_pkg::ST_SRW1, i2cmb_pkg::ST_SRW2:
                begin
                    cnt_next = rw_cnt;
                    if (rw_wait)
                    begin
                        step_next = i2cmb_pkg::ST_SRW2;
                    end
                    else
                    begin
                        timeout_next   = timeout_reg | rw_fail;
                        sda_drive_next = 1'b1;
                        step_next      = i2cmb_pkg::ST_SD1;
                    end
                end
                i2cmb_pkg::ST_SD1:
                begin
                    scl_drive_next = 1'b1;
                    step_next      = i2cmb_pkg::ST_SD2;
                end
                i2cmb_pkg::ST_PD0:
                begin
                    scl_drive_next = 1'b0;
                    cnt_next       = '0;
                    step_next      = i2cmb_pkg::ST_PRW1;
                end
                i2cmb_pkg::ST_PRW1, i2cmb_pkg::ST_PRW2:
                begin
                    cnt_next = rw_cnt;
                    if (rw_wait)
                    begin
                        step_next = i2cmb_pkg::ST_PRW2;
                    end
                    else
                    begin
                        timeout_next   = timeout_reg | rw_fail;
                        sda_drive_next = 1'b0;
                        step_next      = i2cmb_pkg::ST_PD1;
                    end
                end
                i2cmb_pkg::ST_WD0:
                begin
                    scl_drive_next = 1'b0;
                    cnt_next       = '0;
                    step_next      = i2cmb_pkg::ST_WRW1;
                end
                i2cmb_pkg::ST_WRW1, i2cmb_pkg::ST_WRW2:
                begin
                    cnt_next = rw_cnt;
                    if (rw_wait)
                    begin
                        step_next = i2cmb_pkg::ST_WRW2;
                    end
                    else if (rw_fail)
                    begin
                        timeout_next  = 1'b1;
                        ack_hold_next = 1'b0;
                        step_next     = i2cmb_pkg::ST_IDLE;
                        timer_next    = '0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        if (bit_reg >= i2cmb_pkg::BITS_PER_BYTE)
                        begin
                            ack_hold_next = !q_item.sda_in;
                        end
                        scl_drive_next = 1'b1;
                        step_next      = i2cmb_pkg::ST_WD1;
                    end
                end
                i2cmb_pkg::ST_WD1:
                begin
                    if (bit_reg >= i2cmb_pkg::BITS_PER_BYTE)
                    begin
                        step_next  = i2cmb_pkg::ST_IDLE;
                        timer_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        bit_next  = bit_reg + 4'd1;
                        step_next = i2cmb_pkg::ST_WD0;
                        if (bit_reg < i2cmb_pkg::BITS_PER_BYTE - 4'd1)
                        begin
                            sda_drive_next = !shift_reg[7];
                            shift_next     = {shift_reg[6:0], 1'b0};
                        end
                        else
                        begin
                            sda_drive_next = 1'b0;
                        end
                    end
                end
                i2cmb_pkg::ST_RRW1, i2cmb_pkg::ST_RRW2:
                begin
                    cnt_next = rw_cnt;
                    if (rw_wait)
                    begin
                        step_next = i2cmb_pkg::ST_RRW2;
                    end
                    else if (rw_fail)
                    begin
                        timeout_next = 1'b1;
                        rx_hold_next = shift_reg;
                        step_next    = i2cmb_pkg::ST_IDLE;
                        timer_next   = '0;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        shift_next     = {shift_reg[7:1], shift_reg[0] | q_item.sda_in};
                        scl_drive_next = 1'b1;
                        step_next      = i2cmb_pkg::ST_RD1;
                    end
                end
                i2cmb_pkg::ST_RD1:
                begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg < i2cmb_pkg::BITS_PER_BYTE - 4'd1)
                    begin
                        shift_next     = {shift_reg[6:0], 1'b0};
                        scl_drive_next = 1'b0;
                        cnt_next       = '0;
                        step_next      = i2cmb_pkg::ST_RRW1;
                    end
                    else
                    begin
                        sda_drive_next = ack_choice_reg;
                        step_next      = i2cmb_pkg::ST_AD0;
                    end
                end
                i2cmb_pkg::ST_AD0:
                begin
                    scl_drive_next = 1'b0;
                    cnt_next       = '0;
                    step_next      = i2cmb_pkg::ST_ARW1;
                end
                i2cmb_pkg::ST_ARW1, i2cmb_pkg::ST_ARW2:
                begin
                    cnt_next = rw_cnt;
                    if (rw_wait)
                    begin
                        step_next = i2cmb_pkg::ST_ARW2;
                    end
                    else
                    begin
                        timeout_next   = timeout_reg | rw_fail;
                        scl_drive_next = 1'b1;
                        step_next      = i2cmb_pkg::ST_AD1;
                    end
                end
                i2cmb_pkg::ST_AD1:
                begin
                    sda_drive_next = 1'b0;
                    rx_hold_next   = shift_reg;
                    step_next      = i2cmb_pkg::ST_IDLE;
                    timer_next     = '0;
                    done_next      = 1'b1;
                end
                default:
                begin
                    step_next  = i2cmb_pkg::ST_IDLE;
                    timer_next = '0;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    // result item taken from the state after the tick
    always_comb
    begin
        res_ch.valid           = out_valid_reg;
        res_ch.scl_pull_low    = scl_drive_reg;
        res_ch.sda_pull_low    = sda_drive_reg;
        res_ch.busy_res        = (step_reg != i2cmb_pkg::ST_IDLE);
        res_ch.done_res        = done_reg;
        res_ch.rx_byte         = rx_hold_reg;
        res_ch.ack_received    = ack_hold_reg;
        res_ch.stretch_timeout = timeout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= i2cmb_pkg::ST_IDLE;
            bit_reg        <= '0;
            shift_reg      <= '0;
            timer_reg      <= '0;
            cnt_reg        <= '0;
            scl_drive_reg  <= 1'b0;
            sda_drive_reg  <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_hold_reg    <= '0;
            ack_hold_reg   <= 1'b0;
            timeout_reg    <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                step_reg       <= step_next;
                bit_reg        <= bit_next;
                shift_reg      <= shift_next;
                timer_reg      <= timer_next;
                cnt_reg        <= cnt_next;
                scl_drive_reg  <= scl_drive_next;
                sda_drive_reg  <= sda_drive_next;
                ack_choice_reg <= ack_choice_next;
                rx_hold_reg    <= rx_hold_next;
                ack_hold_reg   <= ack_hold_next;
                timeout_reg    <= timeout_next;
                done_reg       <= done_next;
            end
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (step_reg == i2cmb_pkg::ST_IDLE))
        else $error("done pulse while a command is still running");

    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == i2cmb_pkg::ST_IDLE) |-> (timer_reg == '0))
        else $error("half period timer left running in idle");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= i2cmb_pkg::BITS_PER_BYTE)
        else $error("bit index past the ack bit");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed tick produced no result item");

endmodule

`default_nettype wire

/* sv/i2c_master_byte_engine.sv */
// top level of the i2c master byte engine with apb register port
// a result item is held in a register that is loaded when its tick item is taken
// throughput: one tick item per cycle while the result channel does not stall
// the two-entry queue lets intake continue for two items while results stall
// reset: asynchronous active-low, clears sequencer, queue and result holds;
// half period returns to 5 ticks and stretch limit to 1000
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine #(
    parameter int TIMER_WIDTH   = i2cmb_pkg::TIMER_WIDTH_DEFAULT,
    parameter int STRETCH_WIDTH = i2cmb_pkg::STRETCH_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH   = i2cmb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    i2cmb_cmd_if.sink                            cmd_ch,
    i2cmb_res_if.source                          res_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2cmb_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [i2cmb_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [i2cmb_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                 pready
);

    localparam int TMAX = (1 << TIMER_WIDTH) - 1;
    localparam int SMAX = (1 << STRETCH_WIDTH) - 1;

    logic [7:0]               half_period_reg;
    logic [15:0]              stretch_limit_reg;
    logic [7:0]               half_raw;
    logic [TIMER_WIDTH-1:0]   half_ticks;
    logic [STRETCH_WIDTH-1:0] stretch_lim;
    i2cmb_pkg::reg_idx_t      reg_idx;
    logic                     cfg_write;

    i2cmb_pkg::q_status_t     q_status;
    i2cmb_pkg::item_t         push_item;
    i2cmb_pkg::item_t         head_item;
    logic                     push;
    logic                     pop;

    assign pready    = 1'b1;
    assign reg_idx   = i2cmb_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= i2cmb_pkg::HALF_PERIOD_RESET;
            stretch_limit_reg <= i2cmb_pkg::STRETCH_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                i2cmb_pkg::REG_HALF_PERIOD:   half_period_reg   <= pwdata[7:0];
                i2cmb_pkg::REG_STRETCH_LIMIT: stretch_limit_reg <= pwdata[15:0];
                default:                      half_period_reg   <= half_period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            i2cmb_pkg::REG_HALF_PERIOD:   prdata = 32'(half_period_reg);
            i2cmb_pkg::REG_STRETCH_LIMIT: prdata = 32'(stretch_limit_reg);
            default:                      prdata = '0;
        endcase
    end

    // zero half period means default, then saturate to counter ranges
    assign half_raw    = (half_period_reg == 8'd0) ? i2cmb_pkg::ZERO_HALF_TICKS : half_period_reg;
    assign half_ticks  = (32'(half_raw) > 32'(TMAX)) ? TIMER_WIDTH'(TMAX)
                                                      : TIMER_WIDTH'(half_raw);
    assign stretch_lim = (32'(stretch_limit_reg) > 32'(SMAX)) ? STRETCH_WIDTH'(SMAX)
                                                                : STRETCH_WIDTH'(stretch_limit_reg);

    i2cmb_front u_front (
        .cmd_ch   (cmd_ch),
        .q_status (q_status),
        .push     (push),
        .item     (push_item)
    );

    i2cmb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .status    (q_status),
        .head      (head_item)
    );

    i2cmb_back #(
        .TIMER_WIDTH   (TIMER_WIDTH),
        .STRETCH_WIDTH (STRETCH_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_item      (head_item),
        .q_pop       (pop),
        .half_ticks  (half_ticks),
        .stretch_lim (stretch_lim),
        .res_ch      (res_ch)
    );

endmodule

`default_nettype wire
